@@ rtl/sstf_pkg.sv @@
`default_nettype none

package sstf_pkg;

    localparam int POS_W  = 16;
    localparam int SEEK_W = 21;
    localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

    // commands from the sequencer to the request store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mark;
        logic clear_marks;
    } store_cmd_t;

    // read response, valid in the cycle after rd_en
    typedef struct packed {
        logic valid;
        logic served;
    } store_rsp_t;

endpackage

`default_nettype wire

@@ rtl/sstf_store.sv @@
`default_nettype none

module sstf_store #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16,
    parameter int IW           = 5
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sstf_pkg::store_cmd_t   cmd,
    input  wire logic [IW-1:0]          wr_addr,
    input  wire logic [TRACK_BITS-1:0]  wr_data,
    input  wire logic [IW-1:0]          rd_addr,
    input  wire logic [IW-1:0]          mark_addr,
    output sstf_pkg::store_rsp_t        rsp,
    output logic [IW-1:0]               rd_idx,
    output logic [TRACK_BITS-1:0]       rd_data
);
    import sstf_pkg::*;

    logic [TRACK_BITS-1:0]   mem [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] served_reg;
    logic                    rd_valid_reg;
    logic                    rd_served_reg;
    logic [IW-1:0]           rd_idx_reg;
    logic [TRACK_BITS-1:0]   rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            served_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            rd_served_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.rd_en;
            rd_served_reg <= served_reg[rd_addr];
            if (cmd.clear_marks) begin
                served_reg <= '0;
            end else begin
                if (cmd.wr_en) begin
                    served_reg[wr_addr] <= 1'b0;
                end
                if (cmd.mark) begin
                    served_reg[mark_addr] <= 1'b1;
                end
            end
        end
    end

    assign rsp.valid  = rd_valid_reg;
    assign rsp.served = rd_served_reg;
    assign rd_idx     = rd_idx_reg;
    assign rd_data    = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/sstf_disk_scheduler.sv @@
// Shortest-seek-time-first scheduler.
// Input channel (s_*): kind 0 loads the starting head, kind 1 appends a track
// request to the store (dropped once MAX_REQUESTS are held). s_is_last on a
// request starts a scheduling pass; on a head load it is ignored.
// Output channel (m_*): one transfer for the starting head, then one per
// stored request in service order, with the running seek total; m_last marks
// the final transfer of the pass.
// A pass of N requests runs N picks; each pick scans the request memory
// one entry a cycle through its single read port, then the pick state emits
// the nearest unserved request. s_ready is low for the whole pass.
// Results leave through an output register; a stall on m_ready holds the
// sequencer before the next pick until the register drains.
// Reset clears the served marks, the request count, the head and the seek
// total; request memory contents are not cleared. After a pass the head keeps
// the last served track.
`default_nettype none

module sstf_disk_scheduler #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [15:0] s_track,
    input  wire logic        s_is_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [sstf_pkg::POS_W-1:0]  m_position,
    output logic [sstf_pkg::SEEK_W-1:0] m_total_seek,
    output logic             m_last
);
    import sstf_pkg::*;

    localparam int SW    = TRACK_BITS;
    localparam int IW    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW    = $clog2(MAX_REQUESTS + 1);
    localparam int SUM_W = ((SEEK_W > SW) ? SEEK_W : SW) + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_PICK = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     served_cnt_reg, served_cnt_next;
    logic [CW-1:0]     scan_addr_reg, scan_addr_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [SEEK_W-1:0] seek_reg, seek_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [SW-1:0]     best_track_reg, best_track_next;
    logic [SW-1:0]     best_dist_reg, best_dist_next;

    logic              m_valid_reg, m_valid_next;
    logic [POS_W-1:0]  m_position_reg, m_position_next;
    logic [SEEK_W-1:0] m_total_seek_reg, m_total_seek_next;
    logic              m_last_reg, m_last_next;

    store_cmd_t        cmd;
    store_rsp_t        rsp;
    logic [IW-1:0]     rd_idx;
    logic [SW-1:0]     rd_data;
    logic [SW-1:0]     track_in;
    logic [SW-1:0]     seek_dist;
    logic [SUM_W-1:0]  seek_sum;
    logic [SEEK_W-1:0] seek_sat;
    logic              accept;
    logic              out_free;
    logic              pass_done;

    sstf_store #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS),
        .IW           (IW)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .wr_addr   (count_reg[IW-1:0]),
        .wr_data   (track_in),
        .rd_addr   (scan_addr_reg[IW-1:0]),
        .mark_addr (best_idx_reg),
        .rsp       (rsp),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign track_in = SW'(s_track);

    assign seek_dist = (rd_data >= head_reg) ? (rd_data - head_reg) : (head_reg - rd_data);

    assign seek_sum  = SUM_W'(seek_reg) + SUM_W'(best_dist_reg);
    assign seek_sat  = (seek_sum > SUM_W'(SEEK_MAX)) ? SEEK_MAX : SEEK_W'(seek_sum);
    assign pass_done = ((served_cnt_reg + CW'(1)) == count_reg);

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        served_cnt_next   = served_cnt_reg;
        scan_addr_next    = scan_addr_reg;
        head_next         = head_reg;
        seek_next         = seek_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_track_next   = best_track_reg;
        best_dist_next    = best_dist_reg;
        m_valid_next      = m_ready ? 1'b0 : m_valid_reg;
        m_position_next   = m_position_reg;
        m_total_seek_next = m_total_seek_reg;
        m_last_next       = m_last_reg;
        cmd               = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_kind) begin
                        head_next = track_in;
                    end else begin
                        if (count_reg < CW'(MAX_REQUESTS)) begin
                            cmd.wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        if (s_is_last) begin
                            state_next = ST_HEAD;
                        end
                    end
                end
            end
            ST_HEAD: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_position_next   = POS_W'(head_reg);
                    m_total_seek_next = '0;
                    m_last_next       = (count_reg == '0);
                    seek_next         = '0;
                    served_cnt_next   = '0;
                    scan_addr_next    = '0;
                    found_next        = 1'b0;
                    if (count_reg == '0) begin
                        cmd.clear_marks = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_addr_reg < count_reg) begin
                    cmd.rd_en      = 1'b1;
                    scan_addr_next = scan_addr_reg + CW'(1);
                end
                // strict compare keeps the lowest index on a tie
                if (rsp.valid && !rsp.served && (!found_reg || seek_dist < best_dist_reg)) begin
                    found_next      = 1'b1;
                    best_idx_next   = rd_idx;
                    best_track_next = rd_data;
                    best_dist_next  = seek_dist;
                end
                if (scan_addr_reg == count_reg && !rsp.valid) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_position_next   = POS_W'(best_track_reg);
                    m_total_seek_next = seek_sat;
                    m_last_next       = pass_done;
                    seek_next         = seek_sat;
                    head_next         = best_track_reg;
                    cmd.mark          = 1'b1;
                    served_cnt_next   = served_cnt_reg + CW'(1);
                    scan_addr_next    = '0;
                    found_next        = 1'b0;
                    if (pass_done) begin
                        cmd.clear_marks = 1'b1;
                        count_next      = '0;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            scan_addr_reg  <= '0;
            head_reg       <= '0;
            seek_reg       <= '0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            served_cnt_reg <= served_cnt_next;
            scan_addr_reg  <= scan_addr_next;
            head_reg       <= head_next;
            seek_reg       <= seek_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_idx_reg     <= best_idx_next;
        best_track_reg   <= best_track_next;
        best_dist_reg    <= best_dist_next;
        m_position_reg   <= m_position_next;
        m_total_seek_reg <= m_total_seek_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_position   = m_position_reg;
    assign m_total_seek = m_total_seek_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

@@ tb/sv/sstf_seek_checker.sv @@
package sstf_tb_pkg;

    typedef enum logic {
        KIND_HEAD    = 1'b0,
        KIND_REQUEST = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [sstf_pkg::POS_W-1:0]  position;
        logic [sstf_pkg::SEEK_W-1:0] total_seek;
        logic                        last;
    } seek_result_t;

endpackage

module sstf_seek_checker #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_kind,
    input  logic [15:0]                 s_track,
    input  logic                        s_is_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [sstf_pkg::POS_W-1:0]  m_position,
    input  logic [sstf_pkg::SEEK_W-1:0] m_total_seek,
    input  logic                        m_last,
    output int                          errors,
    output int                          expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_tb_pkg::*;

    logic [sstf_pkg::POS_W-1:0] req_track [MAX_REQUESTS];
    int                         req_count;
    logic [sstf_pkg::POS_W-1:0] head;
    seek_result_t               expected_seeks [$];

    initial begin
        errors = 0;
        expected_left = 0;
    end

    // Serve the nearest unserved request each round; ties go to the lower index.
    task automatic schedule_pass();
        logic [MAX_REQUESTS-1:0]    served;
        logic [sstf_pkg::POS_W-1:0] cur;
        logic [sstf_pkg::POS_W-1:0] seek_len;
        logic [sstf_pkg::POS_W-1:0] best_dist;
        logic [sstf_pkg::SEEK_W:0]  total;
        int                         best;
        seek_result_t               res;
        served = '0;
        cur = head;
        total = '0;
        best_dist = '0;
        res.position = cur;
        res.total_seek = '0;
        res.last = (req_count == 0);
        expected_seeks.push_back(res);
        for (int n = 0; n < req_count; n++) begin
            best = -1;
            for (int i = 0; i < req_count; i++) begin
                if (!served[i]) begin
                    seek_len = (req_track[i] >= cur) ? req_track[i] - cur : cur - req_track[i];
                    if (best < 0 || seek_len < best_dist) begin
                        best = i;
                        best_dist = seek_len;
                    end
                end
            end
            served[best] = 1'b1;
            total = total + best_dist;
            if (total > sstf_pkg::SEEK_MAX)
                total = sstf_pkg::SEEK_MAX;
            cur = req_track[best];
            res.position = cur;
            res.total_seek = total[sstf_pkg::SEEK_W-1:0];
            res.last = (n == req_count - 1);
            expected_seeks.push_back(res);
        end
        head = cur;
        req_count = 0;
    endtask

    task automatic absorb_item(input logic kind, input logic [15:0] track, input logic last);
        if (kind == KIND_HEAD) begin
            head = track;
        end else begin
            // full store: the request is lost, but its is_last still starts the pass
            if (req_count < MAX_REQUESTS) begin
                req_track[req_count] = track;
                req_count++;
            end
            if (last)
                schedule_pass();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        seek_result_t want;
        if (!aresetn) begin
            req_count = 0;
            head = '0;
            expected_seeks.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_seeks.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, %s %0d %0d %0b",
                             $time, "got position/seek/last", m_position, m_total_seek,
                             m_last);
                    errors++;
                end else begin
                    want = expected_seeks.pop_front();
                    check_field("position", 32'(m_position), 32'(want.position));
                    check_field("total_seek", 32'(m_total_seek), 32'(want.total_seek));
                    check_field("last", 32'(m_last), 32'(want.last));
                end
            end
            if (s_valid && s_ready)
                absorb_item(s_kind, s_track, s_is_last);
        end
        expected_left = expected_seeks.size();
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstf_tb_pkg::*;

    localparam int MAX_REQUESTS = 32;
    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_OFF     = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int IDLE_PCT     = 19;

    typedef enum {SPREAD, CLUSTER, RIM, LOW_TRACKS} track_mix_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_kind    = 1'b0;
    logic [15:0] s_track   = '0;
    logic        s_is_last = 1'b0;
    logic        m_ready   = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_last;
    logic [sstf_pkg::POS_W-1:0]  m_position;
    logic [sstf_pkg::SEEK_W-1:0] m_total_seek;

    int errors;
    int expected_left;
    int items_issued  = 0;
    int results_taken = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sstf_disk_scheduler #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (16)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_track      (s_track),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_total_seek (m_total_seek),
        .m_last       (m_last)
    );

    sstf_seek_checker #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_track       (s_track),
        .s_is_last     (s_is_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_position    (m_position),
        .m_total_seek  (m_total_seek),
        .m_last        (m_last),
        .errors        (errors),
        .expected_left (expected_left)
    );

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            results_taken <= results_taken + 1;
    end

    // Called at a clock edge; returns at the edge where the transfer happens.
    task automatic issue_item(input item_kind_t kind, input logic [15:0] track,
                              input logic last);
        int gap;
        gap = 0;
        if (items_issued < 120 || items_issued >= 160)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_track   <= track;
        s_is_last <= last;
        do @(posedge aclk); while (!s_ready);
        items_issued++;
    endtask

    function automatic logic [15:0] pick_track(input track_mix_t mix, input logic [15:0] base);
        logic [15:0] t;
        case (mix)
            SPREAD:     t = 16'($urandom_range(0, 65535));
            CLUSTER:    t = base + 16'($urandom_range(0, 15));
            RIM:        t = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                              : 16'($urandom_range(0, 3));
            default:    t = 16'($urandom_range(0, 31));
        endcase
        return t;
    endfunction

    // receiver
    initial begin
        bit held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && m_valid && results_taken >= 40) begin
                // long hold-off mid-pass so the input side backs up
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else begin
                m_ready <= (results_taken >= 100 && results_taken < 150) ||
                           $urandom_range(99) >= IDLE_PCT;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          rand_start;
        int          batch_len;
        bit          first_batch;
        track_mix_t  mix;
        logic [15:0] base;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // head load carrying is_last only moves the head
        issue_item(KIND_HEAD, 16'hFFFF, 1'b0);
        issue_item(KIND_HEAD, 16'h0000, 1'b1);
        issue_item(KIND_REQUEST, 16'hFFFF, 1'b1);
        // no head load: pass starts from the last served track
        issue_item(KIND_REQUEST, 16'h0000, 1'b1);
        // equal distances, a duplicate and a zero-length seek
        issue_item(KIND_HEAD, 16'd100, 1'b0);
        issue_item(KIND_REQUEST, 16'd110, 1'b0);
        issue_item(KIND_REQUEST, 16'd90, 1'b0);
        issue_item(KIND_REQUEST, 16'd110, 1'b0);
        issue_item(KIND_REQUEST, 16'd100, 1'b1);
        issue_item(KIND_HEAD, 16'd1000, 1'b0);
        issue_item(KIND_REQUEST, 16'd990, 1'b0);
        issue_item(KIND_REQUEST, 16'd1010, 1'b1);
        issue_item(KIND_HEAD, 16'h8000, 1'b0);
        issue_item(KIND_REQUEST, 16'h5555, 1'b0);
        issue_item(KIND_REQUEST, 16'hAAAA, 1'b0);
        issue_item(KIND_REQUEST, 16'h8000, 1'b1);
        issue_item(KIND_HEAD, 16'h0000, 1'b1);
        issue_item(KIND_REQUEST, 16'h0000, 1'b1);

        rand_start = items_issued;
        first_batch = 1'b1;
        while (items_issued - rand_start < RANDOM_ITEMS) begin
            mix = track_mix_t'($urandom_range(0, 3));
            base = 16'($urandom_range(0, 65535));
            if ($urandom_range(99) < 75)
                issue_item(KIND_HEAD, pick_track(mix, base), 1'($urandom_range(1)));
            // first batch overruns the store; its is_last lands on a dropped request
            if (first_batch)
                batch_len = MAX_REQUESTS + 4;
            else if ($urandom_range(99) < 8)
                batch_len = $urandom_range(28, 40);
            else
                batch_len = $urandom_range(1, 8);
            first_batch = 1'b0;
            for (int k = 0; k < batch_len; k++) begin
                if ($urandom_range(99) < 5)
                    issue_item(KIND_HEAD, pick_track(mix, base), 1'($urandom_range(1)));
                issue_item(KIND_REQUEST, pick_track(mix, base), k == batch_len - 1);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (expected_left == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
